// ===== hw/rtl/fsba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsba_pkg
// Shared codes, field widths and controller/datapath interface types.
// ---------------------------------------------------------------------------
package fsba_pkg;

	localparam int DEF_HEAP_CELLS    = 64;
	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int DEF_KEY_BITS      = 8;

	// Fixed port widths
	localparam int OP_W    = 2;
	localparam int KEY_W   = 8;
	localparam int REQ_W   = 7;
	localparam int ST_W    = 3;
	localparam int START_W = 6;
	localparam int SIZE_W  = 7;
	localparam int MODE_W  = 2;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_ALIAS = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;
	localparam logic [MODE_W-1:0] FIT_NEXT  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK           = 3'd0;
	localparam logic [ST_W-1:0] ST_EXISTS       = 3'd1;
	localparam logic [ST_W-1:0] ST_NO_FIT       = 3'd2;
	localparam logic [ST_W-1:0] ST_MISSING      = 3'd3;
	localparam logic [ST_W-1:0] ST_DEST_MISSING = 3'd4;
	localparam logic [ST_W-1:0] ST_FULL         = 3'd5;
	localparam logic [ST_W-1:0] ST_BAD_SIZE     = 3'd6;

	typedef struct packed {
		logic            load;
		logic            tstep;
		logic            cstep;
		logic            istep;
		logic            alloc;
		logic            free;
		logic            alias_wr;
		logic            clear;
		logic            fail;
		logic [ST_W-1:0] fail_code;
		logic            publish;
	} fsba_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            t_last;
		logic            scan_end;
		logic            key_hit;
		logic            src_hit;
		logic            slot_hit;
		logic            bad_size;
		logic            found;
	} fsba_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fsba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsba_ctrl
// Sequencer: steps the datapath through table scan, cell scan and commit.
// ---------------------------------------------------------------------------
module fsba_ctrl
	import fsba_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire fsba_stat_t stat,
	output fsba_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TSCAN  = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_CSCAN  = 3'd3;
	localparam logic [2:0] S_PICK   = 3'd4;
	localparam logic [2:0] S_INVAL  = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.fail_code = ST_OK;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_TSCAN;
				end
			end
			S_TSCAN: begin
				cmd.tstep = 1'b1;
				if (stat.t_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_FIN;
				case (stat.op)
					OP_ALLOC: begin
						if (stat.key_hit) begin
							cmd.fail = 1'b1; cmd.fail_code = ST_EXISTS;
						end else if (stat.bad_size) begin
							cmd.fail = 1'b1; cmd.fail_code = ST_BAD_SIZE;
						end else if (!stat.slot_hit) begin
							cmd.fail = 1'b1; cmd.fail_code = ST_FULL;
						end else begin
							state_d = S_CSCAN;
						end
					end
					OP_FREE: begin
						if (!stat.key_hit) begin
							cmd.fail = 1'b1; cmd.fail_code = ST_MISSING;
						end else begin
							cmd.free = 1'b1;
							state_d  = S_INVAL;
						end
					end
					OP_ALIAS: begin
						if (!stat.src_hit) begin
							cmd.fail = 1'b1; cmd.fail_code = ST_MISSING;
						end else if (!stat.key_hit) begin
							cmd.fail = 1'b1; cmd.fail_code = ST_DEST_MISSING;
						end else begin
							cmd.alias_wr = 1'b1;
						end
					end
					default: cmd.clear = 1'b1;
				endcase
			end
			S_CSCAN: begin
				cmd.cstep = 1'b1;
				if (stat.scan_end) state_d = S_PICK;
			end
			S_PICK: begin
				if (stat.found) cmd.alloc = 1'b1;
				else begin
					cmd.fail = 1'b1; cmd.fail_code = ST_NO_FIT;
				end
				state_d = S_FIN;
			end
			S_INVAL: begin
				cmd.istep = 1'b1;
				if (stat.t_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fsba_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fsba_dp
// Cell map, key table, run tracker and result registers.
// ---------------------------------------------------------------------------
module fsba_dp
	import fsba_pkg::*;
#(
	parameter int HEAP_CELLS    = DEF_HEAP_CELLS,
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int KEY_BITS      = DEF_KEY_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fsba_cmd_t          cmd,
	output fsba_stat_t              stat,
	input  wire logic               cfg_wr,
	input  wire logic [MODE_W-1:0]  cfg_mode,
	input  wire logic [OP_W-1:0]    operation,
	input  wire logic [KEY_W-1:0]   var_key,
	input  wire logic [KEY_W-1:0]   source_key,
	input  wire logic [REQ_W-1:0]   request_size,
	output logic [ST_W-1:0]         status,
	output logic [START_W-1:0]      region_start,
	output logic [SIZE_W-1:0]       region_size
);

	localparam int CW = $clog2(HEAP_CELLS);
	localparam int LW = $clog2(HEAP_CELLS + 1);
	localparam int TW = $clog2(TABLE_ENTRIES);

	logic [MODE_W-1:0]        fit_mode_q;
	logic [LW-1:0]            nf_q;
	logic [HEAP_CELLS-1:0]    cell_used_q, scan_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [KEY_BITS-1:0]      ekey_q   [TABLE_ENTRIES];
	logic [CW-1:0]            estart_q [TABLE_ENTRIES];
	logic [LW-1:0]            esize_q  [TABLE_ENTRIES];

	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q, src_q;
	logic [REQ_W-1:0]    need_q;

	logic [TW-1:0] t_q;
	logic [LW-1:0] p_q;
	logic          in_run_q;
	logic [CW-1:0] rstart_q;

	logic          key_hit_q, src_hit_q, slot_hit_q;
	logic [TW-1:0] key_idx_q, slot_idx_q;
	logic [CW-1:0] key_s_q, src_s_q;
	logic [LW-1:0] key_z_q, src_z_q;

	logic          got_q, aft_q, bef_q;
	logic [CW-1:0] best_s_q, aft_s_q, bef_s_q;
	logic [LW-1:0] best_len_q;

	logic [ST_W-1:0] pend_st_q, st_q;
	logic [CW-1:0]   pend_s_q, rs_q;
	logic [LW-1:0]   pend_z_q, rz_q;

	logic          t_valid, t_last, at_end, cell_free, close, fits;
	logic [LW-1:0] run_len;
	logic          found;
	logic [CW-1:0] where;
	logic [LW:0]   ov_s, ov_e, en_s, en_e, rng_s, rng_e;

	assign t_valid   = valid_q[t_q];
	assign t_last    = (t_q == TW'(TABLE_ENTRIES - 1));
	assign at_end    = (p_q == LW'(HEAP_CELLS));
	assign cell_free = !at_end && !scan_q[0];
	assign close     = cmd.cstep && in_run_q && !cell_free;
	assign run_len   = p_q - LW'(rstart_q);
	assign fits      = (32'(run_len) >= 32'(need_q));
	assign found     = (fit_mode_q == FIT_NEXT) ? (aft_q || bef_q) : got_q;
	assign where     = (fit_mode_q == FIT_NEXT) ? (aft_q ? aft_s_q : bef_s_q) : best_s_q;

	assign ov_s = (LW+1)'(key_s_q);
	assign ov_e = (LW+1)'(key_s_q) + (LW+1)'(key_z_q);
	assign en_s = (LW+1)'(estart_q[t_q]);
	assign en_e = (LW+1)'(estart_q[t_q]) + (LW+1)'(esize_q[t_q]);

	assign rng_s = cmd.free ? ov_s : (LW+1)'(where);
	assign rng_e = cmd.free ? ov_e : (LW+1)'(where) + (LW+1)'(need_q);

	assign stat.op       = op_q;
	assign stat.t_last   = t_last;
	assign stat.scan_end = at_end;
	assign stat.key_hit  = key_hit_q;
	assign stat.src_hit  = src_hit_q;
	assign stat.slot_hit = slot_hit_q;
	assign stat.bad_size = (need_q == '0) || (32'(need_q) > 32'(HEAP_CELLS));
	assign stat.found    = found;

	assign status       = st_q;
	assign region_start = START_W'(rs_q);
	assign region_size  = SIZE_W'(rz_q);

	// Mode register, next-fit position, cell map and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q  <= FIT_FIRST;
			nf_q        <= '0;
			cell_used_q <= '0;
			valid_q     <= '0;
		end else begin
			if (cfg_wr) begin
				fit_mode_q <= cfg_mode;
				if (cfg_mode == FIT_NEXT) nf_q <= '0;
			end
			if (cmd.clear) begin
				fit_mode_q  <= FIT_FIRST;
				nf_q        <= '0;
				cell_used_q <= '0;
				valid_q     <= '0;
			end
			if (cmd.alloc || cmd.free) begin
				for (int i = 0; i < HEAP_CELLS; i++) begin
					if ((LW+1)'(i) >= rng_s && (LW+1)'(i) < rng_e)
						cell_used_q[i] <= cmd.alloc;
				end
			end
			if (cmd.alloc) begin
				valid_q[slot_idx_q] <= 1'b1;
				if (fit_mode_q == FIT_NEXT) nf_q <= LW'(rng_e);
			end
			if (cmd.istep && t_valid && en_s < ov_e && ov_s < en_e)
				valid_q[t_q] <= 1'b0;
		end
	end

	// Table payload: no reset
	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			ekey_q[slot_idx_q]   <= key_q;
			estart_q[slot_idx_q] <= where;
			esize_q[slot_idx_q]  <= LW'(need_q);
		end
		if (cmd.alias_wr) begin
			estart_q[key_idx_q] <= src_s_q;
			esize_q[key_idx_q]  <= src_z_q;
		end
	end

	// Request capture, table search and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q        <= '0;
			p_q        <= '0;
			in_run_q   <= 1'b0;
			key_hit_q  <= 1'b0;
			src_hit_q  <= 1'b0;
			slot_hit_q <= 1'b0;
			got_q      <= 1'b0;
			aft_q      <= 1'b0;
			bef_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				t_q        <= '0;
				p_q        <= '0;
				in_run_q   <= 1'b0;
				key_hit_q  <= 1'b0;
				src_hit_q  <= 1'b0;
				slot_hit_q <= 1'b0;
				got_q      <= 1'b0;
				aft_q      <= 1'b0;
				bef_q      <= 1'b0;
			end
			if (cmd.tstep || cmd.istep)
				t_q <= t_last ? '0 : t_q + 1'b1;
			if (cmd.tstep) begin
				if (t_valid && ekey_q[t_q] == key_q && !key_hit_q) key_hit_q <= 1'b1;
				if (t_valid && ekey_q[t_q] == src_q && !src_hit_q) src_hit_q <= 1'b1;
				if (!t_valid && !slot_hit_q) slot_hit_q <= 1'b1;
			end
			if (cmd.cstep && !at_end) begin
				p_q <= p_q + 1'b1;
				if (cell_free && !in_run_q) in_run_q <= 1'b1;
			end
			if (close) begin
				in_run_q <= 1'b0;
				if (fits) begin
					case (fit_mode_q)
						FIT_FIRST: if (!got_q) got_q <= 1'b1;
						FIT_BEST:  if (!got_q || run_len < best_len_q) got_q <= 1'b1;
						FIT_WORST: if (!got_q || run_len > best_len_q) got_q <= 1'b1;
						default: begin
							if (LW'(rstart_q) >= nf_q) aft_q <= 1'b1;
							else bef_q <= 1'b1;
						end
					endcase
				end
			end
		end
	end

	// Payload side of capture and tracking
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			key_q  <= KEY_BITS'(var_key);
			src_q  <= KEY_BITS'(source_key);
			need_q <= request_size;
			scan_q <= cell_used_q;
		end
		if (cmd.tstep) begin
			if (t_valid && ekey_q[t_q] == key_q && !key_hit_q) begin
				key_idx_q <= t_q;
				key_s_q   <= estart_q[t_q];
				key_z_q   <= esize_q[t_q];
			end
			if (t_valid && ekey_q[t_q] == src_q && !src_hit_q) begin
				src_s_q <= estart_q[t_q];
				src_z_q <= esize_q[t_q];
			end
			if (!t_valid && !slot_hit_q) slot_idx_q <= t_q;
		end
		if (cmd.cstep && !at_end) begin
			scan_q <= scan_q >> 1;
			if (cell_free && !in_run_q) rstart_q <= CW'(p_q);
		end
		if (close && fits) begin
			case (fit_mode_q)
				FIT_FIRST: if (!got_q) begin
					best_s_q <= rstart_q; best_len_q <= run_len;
				end
				FIT_BEST: if (!got_q || run_len < best_len_q) begin
					best_s_q <= rstart_q; best_len_q <= run_len;
				end
				FIT_WORST: if (!got_q || run_len > best_len_q) begin
					best_s_q <= rstart_q; best_len_q <= run_len;
				end
				default: begin
					if (LW'(rstart_q) >= nf_q) begin
						if (!aft_q) aft_s_q <= rstart_q;
					end else if (!bef_q) begin
						bef_s_q <= rstart_q;
					end
				end
			endcase
		end
		// Pending result
		if (cmd.fail || cmd.clear) begin
			pend_st_q <= cmd.clear ? ST_OK : cmd.fail_code;
			pend_s_q  <= '0;
			pend_z_q  <= '0;
		end
		if (cmd.alloc) begin
			pend_st_q <= ST_OK; pend_s_q <= where; pend_z_q <= LW'(need_q);
		end
		if (cmd.free) begin
			pend_st_q <= ST_OK; pend_s_q <= key_s_q; pend_z_q <= key_z_q;
		end
		if (cmd.alias_wr) begin
			pend_st_q <= ST_OK; pend_s_q <= src_s_q; pend_z_q <= src_z_q;
		end
		if (cmd.publish) begin
			st_q <= pend_st_q;
			rs_q <= pend_s_q;
			rz_q <= pend_z_q;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fit_strategy_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fit_strategy_block_allocator
// Keyed cell heap allocator with first, best, worst and next fit.
// ---------------------------------------------------------------------------
// One transaction in gives one transaction out. Every command first walks the
// key table one entry per cycle; an allocate then walks the cell map one cell
// per cycle to find the free runs, and a successful free walks the table once
// more to drop overlapping aliases. Commands are handled one at a time; a new
// one is taken while the previous result still waits in the output register.
// Write fit_mode only while idle; a write of next fit restarts the next-fit
// position at cell zero, and clear returns the mode to first fit.
// ---------------------------------------------------------------------------
module fit_strategy_block_allocator
	import fsba_pkg::*;
#(
	parameter int HEAP_CELLS    = DEF_HEAP_CELLS,
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int KEY_BITS      = DEF_KEY_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [MODE_W-1:0] fit_mode,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [KEY_W-1:0]  var_key,
	input  wire logic [KEY_W-1:0]  source_key,
	input  wire logic [REQ_W-1:0]  request_size,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ST_W-1:0]        status,
	output logic [START_W-1:0]     region_start,
	output logic [SIZE_W-1:0]      region_size
);

	fsba_cmd_t  cmd;
	fsba_stat_t stat;

	// The mode register takes a write in any cycle
	assign cfg_ready = 1'b1;

	fsba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fsba_dp #(
		.HEAP_CELLS    (HEAP_CELLS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_BITS      (KEY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_mode     (fit_mode),
		.operation    (operation),
		.var_key      (var_key),
		.source_key   (source_key),
		.request_size (request_size),
		.status       (status),
		.region_start (region_start),
		.region_size  (region_size)
	);

	// Hold off further input once a transaction has been taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a command is in flight");

	// Status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_BAD_SIZE))
		else $error("undefined status code");

	// Errors carry an empty region
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (region_start == '0 && region_size == '0))
		else $error("error result with nonzero region");

	// A reported region never holds more cells than the heap
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(region_size) <= 32'(HEAP_CELLS)))
		else $error("region size beyond heap");

endmodule
`default_nettype wire

// ===== test/tb_fit_strategy_block_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fit_strategy_block_allocator
// Self-checking bench for the keyed cell heap allocator: a heap model predicts
// status, start and size for every command, across all four fit modes.
// ---------------------------------------------------------------------------
module tb_fit_strategy_block_allocator;
	import fsba_pkg::*;

	localparam int CELLS    = 64;
	localparam int ENTRIES  = 16;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [ST_W-1:0]    st;
		logic [START_W-1:0] start;
		logic [SIZE_W-1:0]  size;
	} heap_reply_t;

	// Heap model plus the queue of replies it has predicted
	class heap_scoreboard;
		bit                 used[CELLS];
		bit                 live[ENTRIES];
		logic [KEY_W-1:0]   owner[ENTRIES];
		int                 base[ENTRIES];
		int                 len[ENTRIES];
		logic [MODE_W-1:0]  mode;
		int                 next_pos;
		heap_reply_t        pending[$];
		int                 errors;
		int                 checked;
		int                 ok_allocs;

		function void set_mode(logic [MODE_W-1:0] m);
			mode = m;
			if (m == FIT_NEXT)
				next_pos = 0;
		endfunction

		function int lookup(logic [KEY_W-1:0] k);
			for (int i = 0; i < ENTRIES; i++)
				if (live[i] && owner[i] == k)
					return i;
			return -1;
		endfunction

		// Pick a run by the current mode; -1 when nothing fits
		function int pick_run(int need);
			int i, s, l, got, glen, after, prior;
			i = 0; got = -1; glen = 0; after = -1; prior = -1;
			while (i < CELLS) begin
				if (used[i]) begin
					i++;
					continue;
				end
				s = i;
				while (i < CELLS && !used[i])
					i++;
				l = i - s;
				if (l < need)
					continue;
				case (mode)
					FIT_FIRST: if (got < 0) begin got = s; glen = l; end
					FIT_BEST:  if (got < 0 || l < glen) begin got = s; glen = l; end
					FIT_WORST: if (got < 0 || l > glen) begin got = s; glen = l; end
					default: begin
						if (s >= next_pos) begin
							if (after < 0) after = s;
						end else if (prior < 0) begin
							prior = s;
						end
					end
				endcase
			end
			if (mode == FIT_NEXT)
				return (after >= 0) ? after : prior;
			return got;
		endfunction

		function void note_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
				logic [KEY_W-1:0] src, logic [REQ_W-1:0] need);
			heap_reply_t r;
			int idx, si, slot, w, s, z;
			r = '0;
			case (op)
				OP_ALLOC: begin
					slot = -1;
					if (lookup(k) >= 0) r.st = ST_EXISTS;
					else if (need == 0 || need > CELLS) r.st = ST_BAD_SIZE;
					else begin
						for (int i = ENTRIES - 1; i >= 0; i--)
							if (!live[i]) slot = i;
						if (slot < 0) r.st = ST_FULL;
						else begin
							w = pick_run(int'(need));
							if (w < 0) r.st = ST_NO_FIT;
							else begin
								for (int i = w; i < w + need; i++) used[i] = 1;
								live[slot] = 1; owner[slot] = k;
								base[slot] = w; len[slot] = int'(need);
								if (mode == FIT_NEXT) next_pos = w + need;
								r.start = START_W'(w); r.size = need;
								ok_allocs++;
							end
						end
					end
				end
				OP_FREE: begin
					idx = lookup(k);
					if (idx < 0) r.st = ST_MISSING;
					else begin
						s = base[idx]; z = len[idx];
						for (int i = s; i < s + z && i < CELLS; i++) used[i] = 0;
						// drop every alias that overlaps the freed region
						for (int i = 0; i < ENTRIES; i++)
							if (live[i] && base[i] < s + z && s < base[i] + len[i])
								live[i] = 0;
						live[idx] = 0;
						r.start = START_W'(s); r.size = SIZE_W'(z);
					end
				end
				OP_ALIAS: begin
					si = lookup(src);
					idx = lookup(k);
					if (si < 0) r.st = ST_MISSING;
					else if (idx < 0) r.st = ST_DEST_MISSING;
					else begin
						base[idx] = base[si]; len[idx] = len[si];
						r.start = START_W'(base[si]); r.size = SIZE_W'(len[si]);
					end
				end
				default: begin
					for (int i = 0; i < CELLS; i++) used[i] = 0;
					for (int i = 0; i < ENTRIES; i++) live[i] = 0;
					next_pos = 0;
					mode = FIT_FIRST;
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_reply(heap_reply_t got);
			heap_reply_t exp;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result st=%0d start=%0d size=%0d",
					got.st, got.start, got.size);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.st !== exp.st) begin
				$error("status: expected %0d, actual %0d", exp.st, got.st);
				errors++;
			end
			if (got.start !== exp.start) begin
				$error("region_start: expected %0d, actual %0d", exp.start, got.start);
				errors++;
			end
			if (got.size !== exp.size) begin
				$error("region_size: expected %0d, actual %0d", exp.size, got.size);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [MODE_W-1:0]  fit_mode = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [OP_W-1:0]    operation = '0;
	logic [KEY_W-1:0]   var_key = '0;
	logic [KEY_W-1:0]   source_key = '0;
	logic [REQ_W-1:0]   request_size = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [ST_W-1:0]    status;
	logic [START_W-1:0] region_start;
	logic [SIZE_W-1:0]  region_size;

	heap_scoreboard sb = new();
	bit  stim_done = 0;
	bit  quiet = 0;      // stretch with no idling on either side
	bit  hold_off = 0;   // receiver long stall
	int  idle_cycles = 0;
	int  sent = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	fit_strategy_block_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fit_mode(fit_mode),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.var_key(var_key), .source_key(source_key), .request_size(request_size),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.region_start(region_start), .region_size(region_size)
	);

	// Receiver: sample results at the edge, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reply('{status, region_start, region_size});
		if (!arst_n)
			out_ready <= 0;
		else
			out_ready <= !hold_off && (quiet || $urandom_range(99) >= 10);
	end

	// Watchdog: count cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d results outstanding", sb.pending.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one command and hold it until it is taken
	task automatic send_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] src, logic [REQ_W-1:0] need);
		// step past the edge that dropped the previous valid
		@(posedge clk);
		while (!quiet && $urandom_range(99) < 10)
			@(posedge clk);
		in_valid     <= 1;
		operation    <= op;
		var_key      <= k;
		source_key   <= src;
		request_size <= need;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_command(op, k, src, need);
		sent++;
		in_valid <= 0;
	endtask

	// Wait for every reply, then let the block settle before touching config
	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_mode(logic [MODE_W-1:0] m);
		drain();
		cfg_valid <= 1;
		fit_mode  <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_mode(m);
		cfg_valid <= 0;
	endtask

	// Random command, mostly well-formed against a small key pool
	task automatic random_cmd();
		int pick;
		logic [KEY_W-1:0] k, s;
		logic [REQ_W-1:0] n;
		pick = $urandom_range(99);
		k = ($urandom_range(9) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(19));
		s = ($urandom_range(9) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(19));
		if ($urandom_range(19) == 0)
			n = REQ_W'($urandom);
		else
			n = REQ_W'($urandom_range(12, 1));
		if (pick < 50)      send_cmd(OP_ALLOC, k, s, n);
		else if (pick < 82) send_cmd(OP_FREE, k, s, n);
		else if (pick < 97) send_cmd(OP_ALIAS, k, s, n);
		else                send_cmd(OP_CLEAR, k, s, n);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every status, fill the table
		send_cmd(OP_ALLOC, 8'd5, 8'd0, 7'd0);         // bad size zero
		send_cmd(OP_ALLOC, 8'd5, 8'd0, 7'd65);        // bad size above heap
		send_cmd(OP_ALLOC, 8'd5, 8'd0, 7'd127);
		send_cmd(OP_ALLOC, 8'hFF, 8'hFF, 7'd64);      // whole heap
		send_cmd(OP_ALLOC, 8'hFF, 8'd0, 7'd1);        // key exists
		send_cmd(OP_ALLOC, 8'd1, 8'd0, 7'd1);         // no fit
		send_cmd(OP_FREE, 8'hFF, 8'd0, 7'd0);
		send_cmd(OP_FREE, 8'hFF, 8'd0, 7'd0);         // missing
		send_cmd(OP_ALIAS, 8'd2, 8'd3, 7'd0);         // source missing
		for (int i = 0; i < 17; i++)                   // last one: table full
			send_cmd(OP_ALLOC, KEY_W'(i), 8'd0, 7'd2);
		send_cmd(OP_ALIAS, 8'd99, 8'd1, 7'd0);        // destination missing
		send_cmd(OP_ALIAS, 8'd4, 8'd1, 7'd0);         // alias 4 onto 1
		send_cmd(OP_ALIAS, 8'd4, 8'd4, 7'd0);         // self alias
		send_cmd(OP_FREE, 8'd1, 8'd0, 7'd0);          // drops alias too
		send_cmd(OP_FREE, 8'd4, 8'd0, 7'd0);          // second free: missing
		send_cmd(OP_CLEAR, 8'hAA, 8'h55, 7'h7F);

		// Random phases over every mode, next fit written twice in a row
		for (int ph = 0; ph < 8; ph++) begin
			write_mode(MODE_W'(ph % 4));
			if (ph == 7)
				write_mode(FIT_NEXT);
			quiet = (ph == 2);
			if (ph == 4)
				fork
					begin
						hold_off = 1;
						repeat (2000) @(posedge clk);
						hold_off = 0;
					end
				join_none
			for (int i = 0; i < 110; i++)
				random_cmd();
			quiet = 0;
		end
		drain();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		$display("Ran %0d commands, %0d results checked, %0d successful allocations,",
			sent, sb.checked, sb.ok_allocs);
		$display("all four fit modes, aliasing, clears and every error status.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/fsba_pkg.sv
hw/rtl/fsba_ctrl.sv
hw/rtl/fsba_dp.sv
hw/rtl/fit_strategy_block_allocator.sv
test/tb_fit_strategy_block_allocator.sv
